### src/multi_stack_shared_store_defines.svh
// Assertion macros for the multi-stack shared store
`ifndef MULTI_STACK_SHARED_STORE_DEFINES_SVH
`define MULTI_STACK_SHARED_STORE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define MSS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define MSS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/mss_pkg.sv
package mss_pkg;

   localparam int NUM_STACKS_DEF = 4;
   localparam int CAPACITY_DEF   = 64;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int SID_W     = 2;
   localparam int PAYLOAD_W = 32;
   localparam int ID_SLOTS  = 4;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

### src/multi_stack_shared_store.sv
// Multi-stack shared store: several LIFO stacks share one data memory.
// Request channel (req_valid/req_ready): req_cmd push or pop, req_stack_id
// selects the stack, req_push_value is the value to push.
// Response channel (rsp_valid/rsp_ready): one response per request, with
// rsp_status (ok, overflow on push, underflow on pop) and rsp_pop_value
// (the popped value, zero otherwise).
// Timing: at acceptance the link and data memories are read at the free head
// or the stack top into registers; in the execute state they are written back
// and the response register is loaded, which raises rsp_valid. No new request
// is taken while one is in the execute state.
// Reset: every stack is empty and all entries are free, in ascending order;
// the memories themselves are not cleared, so requests are taken right away.
// Stall: while a response waits, the next request is still accepted and its
// read done; its write-back and response wait until the response register
// drains.
module multi_stack_shared_store #(
   parameter int NUM_STACKS = mss_pkg::NUM_STACKS_DEF,
   parameter int CAPACITY   = mss_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = mss_pkg::DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic [mss_pkg::SID_W-1:0]           req_stack_id,
   input  logic signed [mss_pkg::PAYLOAD_W-1:0] req_push_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic signed [mss_pkg::PAYLOAD_W-1:0] rsp_pop_value
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int PTR_W = $clog2(CAPACITY + 1);
   localparam int TOPS  = (NUM_STACKS < mss_pkg::ID_SLOTS) ? NUM_STACKS : mss_pkg::ID_SLOTS;
   localparam int TOP_W = (TOPS > 1) ? $clog2(TOPS) : 1;
   localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);

   mss_pkg::state_type state_ff, state_in;

   logic [PTR_W-1:0] tops_ff [TOPS];
   logic [PTR_W-1:0] free_head_ff;
   logic [PTR_W-1:0] hwm_ff;

   logic                  cmd_ff;
   logic [TOP_W-1:0]      sid_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic                  ok_ff;
   logic                  fresh_ff;
   logic [DATA_WIDTH-1:0] value_ff;

   logic [PTR_W-1:0]      link_mem [CAPACITY];
   logic [DATA_WIDTH-1:0] data_mem [CAPACITY];
   logic [PTR_W-1:0]      link_rd_ff;
   logic [DATA_WIDTH-1:0] data_rd_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   mss_pkg::status_type             rsp_status_ff;
   logic [mss_pkg::PAYLOAD_W-1:0]   rsp_pop_value_ff;

   logic             accept;
   logic             done;
   logic             sid_ok;
   logic [TOP_W-1:0] sid_idx;
   logic [PTR_W-1:0] top_sel;
   logic             req_push;
   logic [PTR_W-1:0] req_ptr;
   logic             req_ok;
   logic [IDX_W-1:0] req_addr;

   logic             op_push;
   logic [PTR_W-1:0] idx_ptr;
   logic [PTR_W-1:0] nxt;
   logic             link_we;
   logic [PTR_W-1:0] link_wdata;
   logic             data_we;
   logic [63:0]      pop_ext;

   // request decode at acceptance
   always_comb begin
      accept   = req_valid && req_ready;
      sid_ok   = 32'(req_stack_id) < NUM_STACKS;
      sid_idx  = TOP_W'(req_stack_id);
      top_sel  = sid_ok ? tops_ff[sid_idx] : NIL;
      req_push = (req_cmd == mss_pkg::CMD_PUSH);
      req_ptr  = req_push ? free_head_ff : top_sel;
      req_ok   = sid_ok && (req_ptr != NIL);
      req_addr = req_ptr[IDX_W-1:0];
   end

   // write-back pass
   always_comb begin
      op_push    = (cmd_ff == mss_pkg::CMD_PUSH);
      idx_ptr    = PTR_W'(idx_ff);
      nxt        = fresh_ff ? idx_ptr + PTR_W'(1) : link_rd_ff;
      link_we    = done && ok_ff;
      link_wdata = op_push ? tops_ff[sid_ff] : free_head_ff;
      data_we    = done && ok_ff && op_push;
      pop_ext    = 64'($signed(data_rd_ff));
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      done      = 1'b0;
      unique case (state_ff)
         mss_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = mss_pkg::ST_EXEC;
            end
         end
         mss_pkg::ST_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               done     = 1'b1;
               state_in = mss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mss_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOPS; i++) begin
            tops_ff[i] <= NIL;
         end
         free_head_ff <= '0;
         hwm_ff       <= '0;
      end else if (done && ok_ff) begin
         if (op_push) begin
            free_head_ff    <= nxt;
            tops_ff[sid_ff] <= idx_ptr;
            if (fresh_ff) begin
               hwm_ff <= hwm_ff + PTR_W'(1);
            end
         end else begin
            tops_ff[sid_ff] <= nxt;
            free_head_ff    <= idx_ptr;
         end
      end
   end

   // hold the request while it is in flight
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_cmd;
         sid_ff   <= sid_idx;
         idx_ff   <= req_addr;
         ok_ff    <= req_ok;
         fresh_ff <= req_push && (free_head_ff == hwm_ff);
         value_ff <= DATA_WIDTH'(64'(req_push_value));
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         link_rd_ff <= link_mem[req_addr];
      end
      if (link_we) begin
         link_mem[idx_ff] <= link_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_rd_ff <= data_mem[req_addr];
      end
      if (data_we) begin
         data_mem[idx_ff] <= value_ff;
      end
   end

   assign rsp_valid_in = done || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         if (ok_ff) begin
            rsp_status_ff <= mss_pkg::STATUS_OK;
         end else if (op_push) begin
            rsp_status_ff <= mss_pkg::STATUS_OVERFLOW;
         end else begin
            rsp_status_ff <= mss_pkg::STATUS_UNDERFLOW;
         end
         rsp_pop_value_ff <= (ok_ff && !op_push) ? pop_ext[mss_pkg::PAYLOAD_W-1:0] : '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_pop_value = rsp_pop_value_ff;

endmodule

### src/mss_checker.sv
`include "multi_stack_shared_store_defines.svh"

module mss_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                req_cmd,
   input logic [mss_pkg::SID_W-1:0]           req_stack_id,
   input logic signed [mss_pkg::PAYLOAD_W-1:0] req_push_value,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [1:0]                          rsp_status,
   input logic signed [mss_pkg::PAYLOAD_W-1:0] rsp_pop_value
);

   logic [1:0] bad_status;
   logic       req_seen;

   assign bad_status = 2'd3;
   assign req_seen   = req_cmd || (req_stack_id != '0) || (req_push_value != '0) || 1'b1;

   `MSS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready && req_seen, rsp_valid && $stable(rsp_status) && $stable(rsp_pop_value), "response dropped or changed while stalled")
   `MSS_ASSERT_NEXT(a_two_cycle, req_valid && req_ready, !req_ready, "request accepted on consecutive cycles")
   `MSS_ASSERT_SAME(a_status_code, rsp_valid, rsp_status != bad_status, "undefined status code")
   `MSS_ASSERT_SAME(a_fail_zero, rsp_valid && (rsp_status != mss_pkg::STATUS_OK), rsp_pop_value == '0, "nonzero value on failed request")

endmodule

bind multi_stack_shared_store mss_checker u_mss_checker (.*);
